>>> src/msd_pkg.sv
`timescale 1ns / 1ps

package msd_pkg;

    // Default geometry of the load sample and of the running average
    localparam int SAMPLE_BITS_DEF        = 10;
    localparam int AVERAGE_FRACTION_DEF   = 8;

    // Fixed register and field widths
    localparam int SG_BITS       = 10;
    localparam int VEL_BITS      = 16;
    localparam int COUNT_BITS    = 8;
    localparam int REG_IDX_BITS  = 3;
    localparam int REG_DATA_BITS = 16;
    localparam int DEMAND_BITS   = SG_BITS + VEL_BITS;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_SMOOTHING_ENABLE = 3'd0,
        REG_MAX_STALLGUARD   = 3'd1,
        REG_VELOCITY_MAX     = 3'd2,
        REG_NORMAL_MARGIN    = 3'd3,
        REG_GRIP_BUFFER      = 3'd4,
        REG_LOW_COUNT_LIMIT  = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic                  smoothing_enable;
        logic [SG_BITS-1:0]    load_slope;
        logic [VEL_BITS-1:0]   velocity_max;
        logic [SG_BITS-1:0]    normal_margin;
        logic [SG_BITS-1:0]    grip_buffer;
        logic [COUNT_BITS-1:0] low_count_limit;
    } cfg_t;

endpackage

>>> src/msd_regs.sv
`timescale 1ns / 1ps

module msd_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [msd_pkg::REG_IDX_BITS-1:0]   wr_index,
    input  logic [msd_pkg::REG_DATA_BITS-1:0]  wr_data,
    output msd_pkg::cfg_t                      cfg
);
    import msd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_SMOOTHING_ENABLE: cfg_next.smoothing_enable = wr_data[0];
                REG_MAX_STALLGUARD:   cfg_next.load_slope       = wr_data[SG_BITS-1:0];
                REG_VELOCITY_MAX:     cfg_next.velocity_max     = wr_data[VEL_BITS-1:0];
                REG_NORMAL_MARGIN:    cfg_next.normal_margin    = wr_data[SG_BITS-1:0];
                REG_GRIP_BUFFER:      cfg_next.grip_buffer      = wr_data[SG_BITS-1:0];
                REG_LOW_COUNT_LIMIT:  cfg_next.low_count_limit  = wr_data[COUNT_BITS-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing_enable <= 1'b0;
            cfg_reg.load_slope       <= '0;
            cfg_reg.velocity_max     <= VEL_BITS'(1);
            cfg_reg.normal_margin    <= '0;
            cfg_reg.grip_buffer      <= '0;
            cfg_reg.low_count_limit  <= COUNT_BITS'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/msd_front.sv
`timescale 1ns / 1ps

module msd_front #(
    parameter int SAMPLE_BITS = msd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic                              drain,
    input  logic [SAMPLE_BITS-1:0]            load_sample,
    input  logic [msd_pkg::VEL_BITS-1:0]      velocity,
    input  logic                              grip_mode,
    input  logic [msd_pkg::SG_BITS-1:0]       load_slope,
    output logic                              valid,
    output logic [SAMPLE_BITS-1:0]            sample,
    output logic                              grip,
    output logic [msd_pkg::DEMAND_BITS-1:0]   demand
);
    import msd_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   grip_reg;
    logic [DEMAND_BITS-1:0] demand_reg;
    logic [DEMAND_BITS-1:0] demand_next;

    // Right-hand side of the threshold test: load_slope * velocity
    assign demand_next = DEMAND_BITS'(load_slope) * DEMAND_BITS'(velocity);

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (drain)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= load_sample;
            grip_reg   <= grip_mode;
            demand_reg <= demand_next;
        end
    end

    assign valid  = valid_reg;
    assign sample = sample_reg;
    assign grip   = grip_reg;
    assign demand = demand_reg;

endmodule

>>> src/msd_check.sv
`timescale 1ns / 1ps

module msd_check #(
    parameter int SAMPLE_BITS           = msd_pkg::SAMPLE_BITS_DEF,
    parameter int AVERAGE_FRACTION_BITS = msd_pkg::AVERAGE_FRACTION_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              take,
    input  logic [SAMPLE_BITS-1:0]            sample,
    input  logic                              grip,
    input  logic [msd_pkg::DEMAND_BITS-1:0]   demand,
    input  msd_pkg::cfg_t                     cfg,
    output logic                              valid,
    output logic                              stall_event,
    output logic                              stall_sticky,
    output logic [SAMPLE_BITS-1:0]            compared_sample,
    output logic [msd_pkg::COUNT_BITS-1:0]    low_run_count
);
    import msd_pkg::*;

    localparam int AVG_BITS = SAMPLE_BITS + AVERAGE_FRACTION_BITS;
    localparam int SUM_BITS = AVG_BITS + 2;
    localparam int CMP_BITS = ((SAMPLE_BITS > SG_BITS) ? SAMPLE_BITS : SG_BITS) + 1;
    localparam int PRD_BITS = CMP_BITS + VEL_BITS;

    logic                   valid_reg,  valid_next;
    logic [AVG_BITS-1:0]    avg_reg,    avg_next;
    logic [COUNT_BITS-1:0]  count_reg,  count_next;
    logic                   grip_reg,   grip_next;
    logic                   seen_reg,   seen_next;
    logic                   event_reg,  event_next;
    logic [SAMPLE_BITS-1:0] cmp_reg,    cmp_next;

    logic [SUM_BITS-1:0]    avg_sum;
    logic [CMP_BITS-1:0]    level;
    logic [VEL_BITS-1:0]    vmax;
    logic [PRD_BITS-1:0]    supply;
    logic [COUNT_BITS-1:0]  count_inc;
    logic                   is_low;

    // avg' = ((sample << F) + 3 * avg) >> 2
    assign avg_sum = (SUM_BITS'(sample) << AVERAGE_FRACTION_BITS)
                   + (SUM_BITS'(avg_reg) << 1) + SUM_BITS'(avg_reg);

    always_comb
    begin
        avg_next  = avg_reg;
        grip_next = grip_reg;
        cmp_next  = sample;
        if (cfg.smoothing_enable)
        begin
            avg_next = avg_sum[SUM_BITS-1:2];
            cmp_next = avg_next[AVG_BITS-1:AVERAGE_FRACTION_BITS];
            if (grip)
                grip_next = 1'b1;
        end
    end

    assign vmax   = (cfg.velocity_max == '0) ? VEL_BITS'(1) : cfg.velocity_max;
    assign level  = CMP_BITS'(cmp_next)
                  + CMP_BITS'(grip_next ? cfg.grip_buffer : cfg.normal_margin);
    assign supply = PRD_BITS'(level) * PRD_BITS'(vmax);
    assign is_low = supply < PRD_BITS'(demand);
    assign count_inc = count_reg + COUNT_BITS'(1);

    always_comb
    begin
        event_next = 1'b0;
        seen_next  = seen_reg;
        count_next = '0;
        if (is_low)
        begin
            count_next = count_inc;
            if (count_inc >= cfg.low_count_limit)
            begin
                event_next = 1'b1;
                seen_next  = 1'b1;
                count_next = '0;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            avg_reg   <= '0;
            count_reg <= '0;
            grip_reg  <= 1'b0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (advance)
            begin
                avg_reg   <= avg_next;
                count_reg <= count_next;
                grip_reg  <= grip_next;
                seen_reg  <= seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            event_reg <= event_next;
            cmp_reg   <= cmp_next;
        end
    end

    assign valid           = valid_reg;
    assign stall_event     = event_reg;
    assign stall_sticky    = seen_reg;
    assign compared_sample = cmp_reg;
    assign low_run_count   = count_reg;

    a_event_flags: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && event_reg |-> seen_reg && (count_reg == '0))
        else $error("stall event without sticky flag or with nonzero run count");

    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |=> seen_reg)
        else $error("sticky stall flag dropped");

    a_grip_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        grip_reg |=> grip_reg)
        else $error("grip buffer latch dropped");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(count_reg) && $stable(avg_reg))
        else $error("check state moved without a request");

endmodule

>>> src/motor_stall_detector_core.sv
`timescale 1ns / 1ps

// Stall detector for a stepper driver: each request on the slave stream is one periodic
// status check (load sample, velocity, grip mode) and produces exactly one result on the
// master stream. The sample, optionally smoothed by a 1/4 exponential average, is low
// when (sample + buffer) * velocity_max < load_slope * velocity; after
// low_count_limit consecutive low checks a stall event is pulsed and the sticky flag set.
// One check is accepted every clock cycle unless backpressure on the master side holds it.
// From accept to result, a front register stage holds the sample and the
// load_slope * velocity product, and the check stage updates the average, run counter
// and latches into the result register. Backpressure on the master side stalls both
// stages; s_tready follows it combinationally. Configuration writes take effect on the
// next cycle and are meant to be issued only while no check is in flight.
module motor_stall_detector_core #(
    parameter int SAMPLE_BITS           = msd_pkg::SAMPLE_BITS_DEF,
    parameter int AVERAGE_FRACTION_BITS = msd_pkg::AVERAGE_FRACTION_DEF,
    parameter int S_DATA_BITS = ((SAMPLE_BITS + msd_pkg::VEL_BITS + 1 + 7) / 8) * 8,
    parameter int M_DATA_BITS = ((SAMPLE_BITS + msd_pkg::COUNT_BITS + 2 + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port
    input  logic                               wr_en,
    input  logic [msd_pkg::REG_IDX_BITS-1:0]   wr_index,
    input  logic [msd_pkg::REG_DATA_BITS-1:0]  wr_data,
    // Check requests
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // low to high: load_sample, velocity, grip_mode
    input  logic [S_DATA_BITS-1:0]             s_tdata,
    // Check results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // low to high: stall_event, sticky stall indication, compared_sample, low_run_count
    output logic [M_DATA_BITS-1:0]             m_tdata
);
    import msd_pkg::*;

    cfg_t                   cfg;
    logic                   s_accept;
    logic                   advance;
    logic                   take;
    logic                   front_valid;
    logic [SAMPLE_BITS-1:0] front_sample;
    logic                   front_grip;
    logic [DEMAND_BITS-1:0] front_demand;
    logic                   out_valid;
    logic                   stall_event;
    logic                   stall_sticky;
    logic [SAMPLE_BITS-1:0] compared_sample;
    logic [COUNT_BITS-1:0]  low_run_count;

    msd_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // Move the front stage into the result register when the result slot is free or
    // being emptied this cycle; the front stage refills in the same cycle.
    assign take     = out_valid && m_tready;
    assign advance  = front_valid && (!out_valid || m_tready);
    assign s_tready = !front_valid || advance;
    assign s_accept = s_tvalid && s_tready;

    msd_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (s_accept),
        .drain       (advance),
        .load_sample (s_tdata[SAMPLE_BITS-1:0]),
        .velocity    (s_tdata[SAMPLE_BITS +: VEL_BITS]),
        .grip_mode   (s_tdata[SAMPLE_BITS + VEL_BITS]),
        .load_slope  (cfg.load_slope),
        .valid       (front_valid),
        .sample      (front_sample),
        .grip        (front_grip),
        .demand      (front_demand)
    );

    msd_check #(
        .SAMPLE_BITS           (SAMPLE_BITS),
        .AVERAGE_FRACTION_BITS (AVERAGE_FRACTION_BITS)
    ) u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .take            (take),
        .sample          (front_sample),
        .grip            (front_grip),
        .demand          (front_demand),
        .cfg             (cfg),
        .valid           (out_valid),
        .stall_event     (stall_event),
        .stall_sticky    (stall_sticky),
        .compared_sample (compared_sample),
        .low_run_count   (low_run_count)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = M_DATA_BITS'({low_run_count, compared_sample, stall_sticky, stall_event});

endmodule
